[rtl/core/pqv_pkg.sv]
// Shared constants, types and helpers for the particle quad vertex generator.
// Holds the texcoord ROM, the corner rounding/saturation and the fixed-point
// scaling constants. No dependencies.
package pqv_pkg;

	// offset table
	localparam int OFFSET_ENTRIES = 10;
	localparam int SLOT_W = (OFFSET_ENTRIES > 1) ? $clog2(OFFSET_ENTRIES) : 1;

	// index mod OFFSET_ENTRIES by reciprocal: exact for 16-bit indexes
	localparam int SLOT_SH = 20;
	localparam int SLOT_RECIP_W = 21;
	localparam logic [SLOT_RECIP_W-1:0] SLOT_RECIP =
		SLOT_RECIP_W'(((2 ** SLOT_SH) + OFFSET_ENTRIES - 1) / OFFSET_ENTRIES);

	// operation codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_QUAD = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_UP_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UP_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UP_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FWD_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FWD_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FWD_Z = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FOUR_PART = 3'd6;

	// position scale 65535*256/100 = 167769 + 3/5
	localparam logic [17:0] POS_SCALE = 18'd167769;
	// floor(x/5) = (x * DIV5_RECIP) >> DIV5_SH, exact for x < 2^26
	localparam int DIV5_SH = 28;
	localparam logic [25:0] DIV5_RECIP = 26'd53687092;

	// all corner terms in units of 2^-24
	localparam int SUM_W = 44;

	typedef logic signed [15:0] q15_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	function automatic logic [26:0] tex_rom(input logic [4:0] idx);
		logic [26:0] w;
		unique case (idx)
			5'd0:  w = 27'h7FF0000;
			5'd1:  w = 27'h7FF07FF;
			5'd2:  w = 27'h0000000;
			5'd3:  w = 27'h00007FF;
			5'd4:  w = 27'h7FF07FF;
			5'd5:  w = 27'h7FF0000;
			5'd6:  w = 27'h00007FF;
			5'd7:  w = 27'h0000000;
			5'd8:  w = 27'h7FF0000;
			5'd9:  w = 27'h7FF07FF;
			5'd10: w = 27'h0000000;
			5'd11: w = 27'h00007FF;
			5'd12: w = 27'h7FF07FF;
			5'd13: w = 27'h7FF0000;
			5'd14: w = 27'h00007FF;
			5'd15: w = 27'h0000000;
			5'd16: w = 27'h7FF0000;
			5'd17: w = 27'h7FF03FF;
			5'd18: w = 27'h4000000;
			5'd19: w = 27'h40003FF;
			5'd20: w = 27'h7FF0400;
			5'd21: w = 27'h7FF07FF;
			5'd22: w = 27'h4000400;
			5'd23: w = 27'h40007FF;
			5'd24: w = 27'h3FF0000;
			5'd25: w = 27'h3FF03FF;
			5'd26: w = 27'h0000000;
			5'd27: w = 27'h00003FF;
			5'd28: w = 27'h3FF0400;
			5'd29: w = 27'h3FF07FF;
			5'd30: w = 27'h0000400;
			5'd31: w = 27'h00007FF;
		endcase
		return w;
	endfunction

	// ROM column for each corner: TL, TR, BR, BL
	function automatic logic [1:0] corner_tex_sel(input logic [1:0] k);
		logic [1:0] s;
		unique case (k)
			2'd0: s = 2'd2;
			2'd1: s = 2'd3;
			2'd2: s = 2'd1;
			2'd3: s = 2'd0;
		endcase
		return s;
	endfunction

	// divide by 2^24 toward zero, then clamp to int16
	function automatic q15_t corner_sat(input sum_t v);
		logic signed [SUM_W-25:0] q;
		q15_t r;
		q = v[SUM_W-1:24];
		if (v[SUM_W-1] && (v[23:0] != 24'd0))
			q = q + $signed((SUM_W-24)'(1));
		if (q > $signed((SUM_W-24)'(32767)))
			r = 16'sh7FFF;
		else if (q < -$signed((SUM_W-24)'(32768)))
			r = 16'sh8000;
		else
			r = q[15:0];
		return r;
	endfunction

endpackage

[rtl/core/particle_quad_vertex_gen.sv]
// Particle quad vertex generator top level: offset table, five-stage
// fixed-point pipeline and corner serialiser. Uses pqv_pkg.
//
// channel   direction  handshake            payload
// cfg       in         cfg_we               cfg_index, cfg_data
// in        in         in_valid / in_ready  operation, item_index, pos_*, wiggle,
//                                           extent, variation, offset_*
// out       out        out_valid/out_ready  vertex_*, texcoord_word, last_corner
//
// A quad item runs through stages s1..s4 and lands in s5, which hands out
// its four corners one at a time over the single result channel; s5 takes
// no new quad until its last corner has been taken. Load items write the
// offset table at accept and do not enter the pipeline. Reset clears valids,
// the corner count and the camera and four-part registers; the offset table
// is not cleared. A stall holds every occupied stage.
module particle_quad_vertex_gen (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [pqv_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [pqv_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  operation,
	input  logic [15:0]                           item_index,
	input  logic signed [23:0]                    pos_x,
	input  logic signed [23:0]                    pos_y,
	input  logic signed [23:0]                    pos_z,
	input  logic [15:0]                           wiggle,
	input  logic [23:0]                           extent,
	input  logic [2:0]                            variation,
	input  logic signed [15:0]                    offset_x,
	input  logic signed [15:0]                    offset_y,
	input  logic signed [15:0]                    offset_z,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [15:0]                    vertex_x,
	output logic signed [15:0]                    vertex_y,
	output logic signed [15:0]                    vertex_z,
	output logic [26:0]                           texcoord_word,
	output logic                                  last_corner
);

	// configuration
	pqv_pkg::q15_t cam_up_q [3];
	pqv_pkg::q15_t cam_fwd_q [3];
	logic          four_part_q;

	// offset table, per entry x/y/z
	pqv_pkg::q15_t offset_q [pqv_pkg::OFFSET_ENTRIES][3];

	// stage enables
	logic en1, en2, en3, en4, en5;
	logic in_acc;

	// s1
	logic                       v_s1;
	logic [pqv_pkg::SLOT_W-1:0] slot_s1;
	logic signed [23:0]         pos_s1 [3];
	logic [15:0]                wig_s1;
	logic [23:0]                ext_s1;
	logic [2:0]                 row_s1;

	// s2
	logic                v_s2;
	logic signed [40:0]  us_s2 [3];
	logic signed [40:0]  os_s2 [3];
	logic signed [31:0]  owo_s2 [3];
	logic [41:0]         pm_s2 [3];
	logic [22:0]         pd_s2 [3];
	logic [20:0]         fq_s2 [3];
	logic                psgn_s2 [3];
	logic                fsgn_s2 [3];
	logic [23:0]         ext_s2;
	logic [2:0]          row_s2;

	// s3
	logic                v_s3;
	pqv_pkg::sum_t       c_s3 [3];
	pqv_pkg::sum_t       t_s3 [3];
	pqv_pkg::sum_t       oh_s3 [3];
	logic signed [56:0]  wp_s3 [3];
	logic [2:0]          row_s3;

	// s4
	logic          v_s4;
	pqv_pkg::sum_t tl_s4 [3];
	pqv_pkg::sum_t br_s4 [3];
	pqv_pkg::sum_t off_s4 [3];
	logic [2:0]    row_s4;

	// s5: four corners held while they drain
	logic          v_s5;
	pqv_pkg::q15_t crn_s5 [4][3];
	logic [2:0]    row_s5;
	logic [1:0]    cnt_q;

	// combinational
	logic [36:0]                slot_prod;
	logic [15:0]                slot_quo;
	logic [15:0]                slot_rem;
	logic signed [23:0]         pos_in [3];
	pqv_pkg::q15_t              offs_in [3];
	logic signed [24:0]         ext_sg1;
	pqv_pkg::q15_t              wo1;
	pqv_pkg::q15_t              o1 [3];
	logic [23:0]                pmag1 [3];
	logic [24:0]                x3_1 [3];
	logic [50:0]                pd_prod1 [3];
	logic [15:0]                fmag1 [3];
	logic [49:0]                fq_prod1 [3];
	logic signed [24:0]         ext_sg2;
	logic [42:0]                posmag2 [3];
	pqv_pkg::sum_t              pterm2 [3];
	pqv_pkg::sum_t              fterm2 [3];
	logic signed [56:0]         wrnd3 [3];
	pqv_pkg::sum_t              offw3 [3];

	// ---------------------------------------------------------------
	// handshake: each stage moves when its successor has room
	assign en5 = !v_s5 || (out_ready && (cnt_q == 2'd3));
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;
	assign in_acc = in_valid && in_ready;

	// ---------------------------------------------------------------
	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				cam_up_q[a]  <= '0;
				cam_fwd_q[a] <= '0;
			end
			four_part_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pqv_pkg::REG_UP_X:      cam_up_q[0]  <= cfg_data;
				pqv_pkg::REG_UP_Y:      cam_up_q[1]  <= cfg_data;
				pqv_pkg::REG_UP_Z:      cam_up_q[2]  <= cfg_data;
				pqv_pkg::REG_FWD_X:     cam_fwd_q[0] <= cfg_data;
				pqv_pkg::REG_FWD_Y:     cam_fwd_q[1] <= cfg_data;
				pqv_pkg::REG_FWD_Z:     cam_fwd_q[2] <= cfg_data;
				pqv_pkg::REG_FOUR_PART: four_part_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// input side: table load and slot select
	assign pos_in[0]  = pos_x;
	assign pos_in[1]  = pos_y;
	assign pos_in[2]  = pos_z;
	assign offs_in[0] = offset_x;
	assign offs_in[1] = offset_y;
	assign offs_in[2] = offset_z;

	always_comb begin
		slot_prod = 37'(item_index) * 37'(pqv_pkg::SLOT_RECIP);
		slot_quo  = slot_prod[pqv_pkg::SLOT_SH +: 16];
		slot_rem  = item_index - 16'(slot_quo * 16'(pqv_pkg::OFFSET_ENTRIES));
	end

	// a quad in s1 moves on at the same edge a new load is taken, so it
	// always sees the table as it was before that load
	always_ff @(posedge clk) begin
		if (in_acc && (operation == pqv_pkg::OP_LOAD)
				&& (item_index < 16'(pqv_pkg::OFFSET_ENTRIES))) begin
			for (int a = 0; a < 3; a++)
				offset_q[item_index[pqv_pkg::SLOT_W-1:0]][a] <= offs_in[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en1)
			v_s1 <= in_valid && (operation == pqv_pkg::OP_QUAD);
	end

	always_ff @(posedge clk) begin
		if (in_acc && (operation == pqv_pkg::OP_QUAD)) begin
			slot_s1 <= slot_rem[pqv_pkg::SLOT_W-1:0];
			for (int a = 0; a < 3; a++)
				pos_s1[a] <= pos_in[a];
			wig_s1 <= wiggle;
			ext_s1 <= extent;
			row_s1 <= {variation[2] ^ four_part_q, variation[1:0]};
		end
	end

	// ---------------------------------------------------------------
	// s1 -> s2: table read and first products
	always_comb begin
		ext_sg1 = $signed({1'b0, ext_s1});
		wo1 = $signed({~wig_s1[15], wig_s1[14:0]});	// wiggle - 0.5
		for (int a = 0; a < 3; a++) begin
			o1[a]       = offset_q[slot_s1][a];
			pmag1[a]    = pos_s1[a][23] ? (~pos_s1[a] + 24'd1) : pos_s1[a];
			x3_1[a]     = 25'({pmag1[a], 1'b0}) + 25'(pmag1[a]);
			pd_prod1[a] = 51'(x3_1[a]) * 51'(pqv_pkg::DIV5_RECIP);
			fmag1[a]    = cam_fwd_q[a][15] ? (~cam_fwd_q[a] + 16'd1) : cam_fwd_q[a];
			fq_prod1[a] = 50'({fmag1[a], 8'd0}) * 50'(pqv_pkg::DIV5_RECIP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en2)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			for (int a = 0; a < 3; a++) begin
				us_s2[a]   <= cam_up_q[a] * ext_sg1;
				os_s2[a]   <= o1[a] * ext_sg1;
				owo_s2[a]  <= o1[a] * wo1;
				pm_s2[a]   <= 42'(pmag1[a]) * 42'(pqv_pkg::POS_SCALE);
				pd_s2[a]   <= pd_prod1[a][pqv_pkg::DIV5_SH +: 23];
				fq_s2[a]   <= fq_prod1[a][pqv_pkg::DIV5_SH +: 21];
				psgn_s2[a] <= pos_s1[a][23];
				fsgn_s2[a] <= cam_fwd_q[a][15];
			end
			ext_s2 <= ext_s1;
			row_s2 <= row_s1;
		end
	end

	// ---------------------------------------------------------------
	// s2 -> s3: centre term and wiggle product
	always_comb begin
		ext_sg2 = $signed({1'b0, ext_s2});
		for (int a = 0; a < 3; a++) begin
			posmag2[a] = 43'(pm_s2[a]) + 43'(pd_s2[a]);
			pterm2[a]  = psgn_s2[a] ? -pqv_pkg::sum_t'(posmag2[a])
			                        : pqv_pkg::sum_t'(posmag2[a]);
			fterm2[a]  = fsgn_s2[a] ? -pqv_pkg::sum_t'(fq_s2[a])
			                        : pqv_pkg::sum_t'(fq_s2[a]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en3)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			for (int a = 0; a < 3; a++) begin
				c_s3[a]  <= pterm2[a] + fterm2[a];
				t_s3[a]  <= pqv_pkg::sum_t'(us_s2[a]);
				oh_s3[a] <= pqv_pkg::sum_t'(os_s2[a]);
				wp_s3[a] <= owo_s2[a] * ext_sg2;
			end
			row_s3 <= row_s2;
		end
	end

	// ---------------------------------------------------------------
	// s3 -> s4: wiggle term (2*o*s*w / 65536 toward zero) and edge sums
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			wrnd3[a] = wp_s3[a] + (wp_s3[a][56] ? 57'sd32767 : 57'sd0);
			offw3[a] = pqv_pkg::sum_t'(wrnd3[a] >>> 15);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en4)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			for (int a = 0; a < 3; a++) begin
				tl_s4[a]  <= t_s3[a] + c_s3[a] + offw3[a];
				br_s4[a]  <= c_s3[a] - t_s3[a] - oh_s3[a];
				off_s4[a] <= oh_s3[a] <<< 1;
			end
			row_s4 <= row_s3;
		end
	end

	// ---------------------------------------------------------------
	// s4 -> s5: corners, rounded and clamped; s5 drains one per cycle while out_ready is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5  <= 1'b0;
			cnt_q <= 2'd0;
		end else if (en5) begin
			v_s5  <= v_s4;
			cnt_q <= 2'd0;
		end else if (out_ready) begin
			cnt_q <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en5 && v_s4) begin
			for (int a = 0; a < 3; a++) begin
				crn_s5[0][a] <= pqv_pkg::corner_sat(tl_s4[a]);
				crn_s5[1][a] <= pqv_pkg::corner_sat(tl_s4[a] + off_s4[a]);
				crn_s5[2][a] <= pqv_pkg::corner_sat(br_s4[a] + off_s4[a]);
				crn_s5[3][a] <= pqv_pkg::corner_sat(br_s4[a]);
			end
			row_s5 <= row_s4;
		end
	end

	assign out_valid     = v_s5;
	assign vertex_x      = crn_s5[cnt_q][0];
	assign vertex_y      = crn_s5[cnt_q][1];
	assign vertex_z      = crn_s5[cnt_q][2];
	assign texcoord_word = pqv_pkg::tex_rom({row_s5, pqv_pkg::corner_tex_sel(cnt_q)});
	assign last_corner   = (cnt_q == 2'd3);

endmodule
